>>> hw/rtl/gfrc_pkg.sv
// Package for the geofence region classifier.
// Holds operation codes, controller states, the command and status words,
// and default sizes. No dependencies.
package gfrc_pkg;

   localparam int MAX_VERTICES_DEF = 64;
   localparam int MAX_POLYGONS_DEF = 8;

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_LOAD  = 2'd1;
   localparam logic [1:0] OP_TEST  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_LOAD,
      ST_TEST_PRIME,
      ST_TEST_EDGE,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic capture;   // latch request word, reset walk and flags
      logic clear;     // drop all polygons
      logic load;      // store one vertex
      logic prime;     // read closing vertex of current polygon
      logic step;      // read next edge vertex
      logic publish;   // move result into response register
   } cmd_type;

   typedef struct packed {
      logic more_polys;
      logic at_last;
      logic found;
      logic pipe_empty;
   } status_type;

endpackage

>>> hw/rtl/gfrc_ctrl.sv
// Controller FSM for the geofence region classifier.
// Sequences clear, load and test walks and owns both handshakes.
// Depends on gfrc_pkg.
module gfrc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [1:0]            req_operation,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  gfrc_pkg::status_type  status,
   output gfrc_pkg::cmd_type     cmd
);

   gfrc_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic can_publish;

   assign can_publish = !(rsp_valid_ff && rsp_stall);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gfrc_pkg::ST_IDLE: begin
            if (req_valid) begin
               unique case (req_operation)
                  gfrc_pkg::OP_CLEAR: state_in = gfrc_pkg::ST_CLEAR;
                  gfrc_pkg::OP_LOAD:  state_in = gfrc_pkg::ST_LOAD;
                  gfrc_pkg::OP_TEST:  state_in = gfrc_pkg::ST_TEST_PRIME;
                  default:            state_in = gfrc_pkg::ST_FINISH;
               endcase
            end
         end
         gfrc_pkg::ST_CLEAR: state_in = gfrc_pkg::ST_FINISH;
         gfrc_pkg::ST_LOAD:  state_in = gfrc_pkg::ST_FINISH;
         gfrc_pkg::ST_TEST_PRIME: begin
            if (status.more_polys && !status.found) state_in = gfrc_pkg::ST_TEST_EDGE;
            else                                   state_in = gfrc_pkg::ST_DRAIN;
         end
         gfrc_pkg::ST_TEST_EDGE: begin
            if (status.at_last) state_in = gfrc_pkg::ST_TEST_PRIME;
         end
         gfrc_pkg::ST_DRAIN: begin
            if (status.pipe_empty) state_in = gfrc_pkg::ST_FINISH;
         end
         gfrc_pkg::ST_FINISH: begin
            if (can_publish) state_in = gfrc_pkg::ST_IDLE;
         end
         default: state_in = gfrc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         gfrc_pkg::ST_IDLE:       cmd.capture = req_valid;
         gfrc_pkg::ST_CLEAR:      cmd.clear   = 1'b1;
         gfrc_pkg::ST_LOAD:       cmd.load    = 1'b1;
         gfrc_pkg::ST_TEST_PRIME: cmd.prime   = status.more_polys && !status.found;
         gfrc_pkg::ST_TEST_EDGE:  cmd.step    = 1'b1;
         gfrc_pkg::ST_DRAIN:      cmd         = '0;
         gfrc_pkg::ST_FINISH:     cmd.publish = can_publish;
         default:                 cmd         = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.publish)              rsp_valid_in = 1'b1;
      else if (!rsp_stall)          rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gfrc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != gfrc_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> hw/rtl/gfrc_dpath.sv
// Datapath for the geofence region classifier: vertex store, polygon table,
// counters, edge walk and the four-stage edge crossing pipeline.
// Depends on gfrc_pkg.
module gfrc_dpath #(
   parameter int MAX_VERTICES = gfrc_pkg::MAX_VERTICES_DEF,
   parameter int MAX_POLYGONS = gfrc_pkg::MAX_POLYGONS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            req_operation,
   input  logic signed [31:0]    req_point_lon,
   input  logic signed [30:0]    req_point_lat,
   input  logic                  req_end_of_polygon,
   input  gfrc_pkg::cmd_type     cmd,
   output gfrc_pkg::status_type  status,
   output logic                  rsp_matched,
   output logic [2:0]            rsp_region,
   output logic                  rsp_store_full
);

   localparam int VW  = $clog2(MAX_VERTICES);
   localparam int VCW = $clog2(MAX_VERTICES + 1);
   localparam int PW  = (MAX_POLYGONS > 1) ? $clog2(MAX_POLYGONS) : 1;
   localparam int PCW = $clog2(MAX_POLYGONS + 1);
   localparam int PD  = 2 ** PW;

   // request word
   logic [1:0]         op_ff;
   logic signed [31:0] pt_lon_ff;
   logic signed [30:0] pt_lat_ff;
   logic               end_ff;

   // store and counters
   logic signed [31:0] vert_lon_ff [MAX_VERTICES];
   logic signed [30:0] vert_lat_ff [MAX_VERTICES];
   logic [VW-1:0]      last_vtx_ff [PD];
   logic [VCW-1:0]     vcount_ff;
   logic [PCW-1:0]     pcount_ff;
   logic               full_ff;
   logic               store_full;

   // walk
   logic [PCW-1:0]     walk_poly_ff;
   logic [VW-1:0]      walk_addr_ff;
   logic [VW-1:0]      cur_last;
   logic [VW-1:0]      rd_addr;

   // stage 1: read data
   logic               s1_valid_ff, s1_prime_ff, s1_end_ff;
   logic signed [31:0] rd_lon_ff;
   logic signed [30:0] rd_lat_ff;
   logic signed [31:0] prev_lon_ff;
   logic signed [30:0] prev_lat_ff;

   // stage 2: differences and flags
   logic               s2_valid_ff, s2_end_ff, s2_count_ff, s2_dypos_ff;
   logic signed [31:0] s2_dy_ff, s2_dyi_ff;
   logic signed [32:0] s2_dxj_ff, s2_dxp_ff;
   logic               straddle, xok;

   // stage 3: products
   logic               s3_valid_ff, s3_end_ff, s3_count_ff, s3_dypos_ff;
   logic signed [64:0] s3_lhs_ff, s3_rhs_ff;

   // stage 4: parity and match
   logic               crossing, odd_new;
   logic               odd_ff, found_ff;
   logic [PCW-1:0]     d_poly_ff;
   logic [2:0]         found_region_ff;

   // response register
   logic               rsp_matched_ff, rsp_store_full_ff;
   logic [2:0]         rsp_region_ff;

   assign store_full = (vcount_ff >= VCW'(MAX_VERTICES)) || (pcount_ff >= PCW'(MAX_POLYGONS));
   assign cur_last   = last_vtx_ff[walk_poly_ff[PW-1:0]];
   assign rd_addr    = cmd.prime ? cur_last : walk_addr_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= req_operation;
         pt_lon_ff <= req_point_lon;
         pt_lat_ff <= req_point_lat;
         end_ff    <= req_end_of_polygon;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= '0;
         pcount_ff <= '0;
         full_ff   <= 1'b0;
      end else if (cmd.capture) begin
         full_ff <= 1'b0;
      end else if (cmd.clear) begin
         vcount_ff <= '0;
         pcount_ff <= '0;
      end else if (cmd.load) begin
         if (store_full) begin
            full_ff <= 1'b1;
         end else begin
            vcount_ff <= vcount_ff + VCW'(1);
            if (end_ff) pcount_ff <= pcount_ff + PCW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load && !store_full) begin
         vert_lon_ff[vcount_ff[VW-1:0]] <= pt_lon_ff;
         vert_lat_ff[vcount_ff[VW-1:0]] <= pt_lat_ff;
         if (end_ff) last_vtx_ff[pcount_ff[PW-1:0]] <= vcount_ff[VW-1:0];
      end
      rd_lon_ff <= vert_lon_ff[rd_addr];
      rd_lat_ff <= vert_lat_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         walk_poly_ff <= '0;
         walk_addr_ff <= '0;
      end else if (cmd.step) begin
         walk_addr_ff <= walk_addr_ff + VW'(1);
         if (walk_addr_ff == cur_last) walk_poly_ff <= walk_poly_ff + PCW'(1);
      end
   end

   assign status.more_polys = (walk_poly_ff < pcount_ff);
   assign status.at_last    = (walk_addr_ff == cur_last);
   assign status.found      = found_ff;
   assign status.pipe_empty = !s1_valid_ff && !s2_valid_ff && !s3_valid_ff;

   // stage 1 tags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.prime || cmd.step;
      end
      s1_prime_ff <= cmd.prime;
      s1_end_ff   <= cmd.step && (walk_addr_ff == cur_last);
   end

   // stage 2: vertex i is the read data, vertex j the previous one
   assign straddle = ((rd_lat_ff < pt_lat_ff) && (prev_lat_ff >= pt_lat_ff)) ||
                     ((prev_lat_ff < pt_lat_ff) && (rd_lat_ff >= pt_lat_ff));
   assign xok      = (rd_lon_ff <= pt_lon_ff) || (prev_lon_ff <= pt_lon_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff && !s1_prime_ff;
      end
      if (s1_valid_ff) begin
         prev_lon_ff <= rd_lon_ff;
         prev_lat_ff <= rd_lat_ff;
      end
      s2_end_ff   <= s1_end_ff;
      s2_count_ff <= straddle && xok;
      s2_dypos_ff <= (prev_lat_ff > rd_lat_ff);
      s2_dy_ff    <= 32'(prev_lat_ff) - 32'(rd_lat_ff);
      s2_dyi_ff   <= 32'(pt_lat_ff) - 32'(rd_lat_ff);
      s2_dxj_ff   <= 33'(prev_lon_ff) - 33'(rd_lon_ff);
      s2_dxp_ff   <= 33'(pt_lon_ff) - 33'(rd_lon_ff);
   end

   // stage 3: cross-multiply
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_end_ff   <= s2_end_ff;
      s3_count_ff <= s2_count_ff;
      s3_dypos_ff <= s2_dypos_ff;
      s3_lhs_ff   <= s2_dyi_ff * s2_dxj_ff;
      s3_rhs_ff   <= s2_dxp_ff * s2_dy_ff;
   end

   // stage 4: parity per polygon, first match wins
   assign crossing = s3_dypos_ff ? (s3_lhs_ff < s3_rhs_ff) : (s3_lhs_ff > s3_rhs_ff);
   assign odd_new  = odd_ff ^ (s3_count_ff && crossing);

   always_ff @(posedge clock) begin
      if (reset) begin
         odd_ff    <= 1'b0;
         found_ff  <= 1'b0;
         d_poly_ff <= '0;
      end else if (cmd.capture) begin
         odd_ff    <= 1'b0;
         found_ff  <= 1'b0;
         d_poly_ff <= '0;
      end else if (s3_valid_ff) begin
         if (s3_end_ff) begin
            odd_ff    <= 1'b0;
            d_poly_ff <= d_poly_ff + PCW'(1);
            if (odd_new && !found_ff) begin
               found_ff        <= 1'b1;
               found_region_ff <= 3'(d_poly_ff);
            end
         end else begin
            odd_ff <= odd_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_matched_ff    <= (op_ff == gfrc_pkg::OP_TEST) && found_ff;
         rsp_region_ff     <= ((op_ff == gfrc_pkg::OP_TEST) && found_ff) ?
                              found_region_ff : 3'd0;
         rsp_store_full_ff <= (op_ff == gfrc_pkg::OP_LOAD) && full_ff;
      end
   end

   assign rsp_matched    = rsp_matched_ff;
   assign rsp_region     = rsp_region_ff;
   assign rsp_store_full = rsp_store_full_ff;

endmodule

>>> hw/rtl/geofence_region_classifier.sv
// Geofence region classifier: keeps up to MAX_POLYGONS polygons built from a
// shared store of MAX_VERTICES vertices and reports the first polygon, in load
// order, that holds a test point by the even-odd rule with exact cross-multiply
// edge compares. One word is in flight at a time; a result waiting in the
// response register does not block the next request. Clear and load pass
// through their own state to the finish state, an unused code goes straight
// there, and the finish state waits for the response register to be free.
// A test walks the stored vertices of each polygon in turn: the single read
// port of the vertex store gives one edge per cycle plus one read per polygon
// for its closing vertex, then the 4-stage compare pipeline drains. The walk
// stops at the first polygon boundary after a match leaves the compare
// pipeline. The store needs no clearing pass after reset. Depends on gfrc_pkg,
// gfrc_ctrl and gfrc_dpath.
module geofence_region_classifier #(
   parameter int MAX_VERTICES = gfrc_pkg::MAX_VERTICES_DEF,
   parameter int MAX_POLYGONS = gfrc_pkg::MAX_POLYGONS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_operation,
   input  logic signed [31:0] req_point_lon,
   input  logic signed [30:0] req_point_lat,
   input  logic               req_end_of_polygon,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_matched,
   output logic [2:0]         rsp_region,
   output logic               rsp_store_full
);

   gfrc_pkg::cmd_type    cmd;
   gfrc_pkg::status_type status;

   gfrc_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .status        (status),
      .cmd           (cmd)
   );

   gfrc_dpath #(
      .MAX_VERTICES (MAX_VERTICES),
      .MAX_POLYGONS (MAX_POLYGONS)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .req_operation      (req_operation),
      .req_point_lon      (req_point_lon),
      .req_point_lat      (req_point_lat),
      .req_end_of_polygon (req_end_of_polygon),
      .cmd                (cmd),
      .status             (status),
      .rsp_matched        (rsp_matched),
      .rsp_region         (rsp_region),
      .rsp_store_full     (rsp_store_full)
   );

endmodule

>>> hw/rtl/gfrc_checker.sv
// Port-level checker for the geofence region classifier, bound to the top.
// Depends only on the top level's ports.
module gfrc_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic [1:0]         req_operation,
   input logic signed [31:0] req_point_lon,
   input logic signed [30:0] req_point_lat,
   input logic               req_end_of_polygon,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic               rsp_matched,
   input logic [2:0]         rsp_region,
   input logic               rsp_store_full
);

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_matched) &&
                                 $stable(rsp_region) && $stable(rsp_store_full))
      else $error("stalled response word changed");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request accepted while one is in flight");

   a_match_xor_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_matched && rsp_store_full))
      else $error("match and store full in one word");

   a_region_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_matched |-> rsp_region == 3'd0)
      else $error("region set without a match");

endmodule

bind geofence_region_classifier gfrc_checker u_gfrc_checker (.*);
